[design/bma_pkg.sv]
// Shared types for the 64-bit bit-manipulation unit: operation codes and
// the payload carried between the three pipeline stages.
// No dependencies.
package bma_pkg;

    localparam int XLEN   = 64;
    localparam int CNT_W  = 7;
    localparam int AMT_W  = 6;
    localparam int NBYTES = XLEN / 8;

    // Operation codes as carried on the input tuser field
    typedef enum logic [4:0] {
        OP_ANDN  = 5'd0,
        OP_ORN   = 5'd1,
        OP_XNOR  = 5'd2,
        OP_CLZ   = 5'd3,
        OP_CLZW  = 5'd4,
        OP_CTZ   = 5'd5,
        OP_CTZW  = 5'd6,
        OP_CPOP  = 5'd7,
        OP_CPOPW = 5'd8,
        OP_MAX   = 5'd9,
        OP_MAXU  = 5'd10,
        OP_MIN   = 5'd11,
        OP_MINU  = 5'd12,
        OP_SEXTB = 5'd13,
        OP_SEXTH = 5'd14,
        OP_ZEXTH = 5'd15,
        OP_ROL   = 5'd16,
        OP_ROLW  = 5'd17,
        OP_ROR   = 5'd18,
        OP_RORI  = 5'd19,
        OP_RORIW = 5'd20,
        OP_RORW  = 5'd21,
        OP_ORCB  = 5'd22,
        OP_REV8  = 5'd23
    } op_t;

    // Stage 1 -> stage 2: coarse rotate done, per-byte counts ready
    typedef struct packed {
        op_t                        op;
        logic [XLEN-1:0]            simple;
        logic [XLEN-1:0]            rot;
        logic [2:0]                 fine_amt;
        logic [NBYTES-1:0][3:0]     pcnt;
        logic [NBYTES-1:0]          nz;
        logic [NBYTES-1:0][2:0]     tz;
    } s1_t;

    // Stage 2 -> stage 3: rotate and counts fully reduced
    typedef struct packed {
        op_t                        op;
        logic [XLEN-1:0]            simple;
        logic [XLEN-1:0]            rot;
        logic [CNT_W-1:0]           cnt;
    } s2_t;

endpackage

[design/bma_prep.sv]
// Stage 1 of the bit-manipulation pipeline: logic ops, compares, extends,
// byte ops, rotate amount and coarse byte rotate, per-byte count terms.
// Depends on bma_pkg.
module bma_prep (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  bma_pkg::op_t            in_op,
    input  logic [bma_pkg::XLEN-1:0] in_a,
    input  logic [bma_pkg::XLEN-1:0] in_b,
    output logic                    out_valid,
    input  logic                    out_ready,
    output bma_pkg::s1_t            out_data
);

    logic                       valid_reg;
    bma_pkg::s1_t               data_reg;
    bma_pkg::s1_t               data_next;

    logic                       slt;
    logic                       ult;
    logic [bma_pkg::AMT_W-1:0]  amt;
    logic [bma_pkg::XLEN-1:0]   rot_src;
    logic [2*bma_pkg::XLEN-1:0] rot_dbl;
    logic [bma_pkg::XLEN-1:0]   rev_a;
    logic [bma_pkg::XLEN-1:0]   cnt_src;
    logic [bma_pkg::XLEN-1:0]   pop_src;
    logic [bma_pkg::XLEN-1:0]   orcb;
    logic [bma_pkg::XLEN-1:0]   rev8;
    logic [bma_pkg::XLEN-1:0]   simple_res;

    // Lowest set bit position within one byte
    function automatic logic [2:0] byte_tz(input logic [7:0] x);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (x[i])
            begin
                n = 3'(i);
            end
        end
        return n;
    endfunction

    // Population count of one byte
    function automatic logic [3:0] byte_pop(input logic [7:0] x);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(x[i]);
        end
        return n;
    endfunction

    // Compares, bit reversal and byte operations
    always_comb
    begin
        slt = $signed(in_a) < $signed(in_b);
        ult = in_a < in_b;
        for (int i = 0; i < bma_pkg::XLEN; i++)
        begin
            rev_a[i] = in_a[bma_pkg::XLEN-1-i];
        end
        for (int k = 0; k < bma_pkg::NBYTES; k++)
        begin
            orcb[k*8 +: 8] = (|in_a[k*8 +: 8]) ? 8'hFF : 8'h00;
            rev8[k*8 +: 8] = in_a[(bma_pkg::NBYTES-1-k)*8 +: 8];
        end
    end

    // Results that need no further stages
    always_comb
    begin
        case (in_op)
            bma_pkg::OP_ANDN:  simple_res = in_a & ~in_b;
            bma_pkg::OP_ORN:   simple_res = in_a | ~in_b;
            bma_pkg::OP_XNOR:  simple_res = ~(in_a ^ in_b);
            bma_pkg::OP_MAX:   simple_res = slt ? in_b : in_a;
            bma_pkg::OP_MAXU:  simple_res = ult ? in_b : in_a;
            bma_pkg::OP_MIN:   simple_res = slt ? in_a : in_b;
            bma_pkg::OP_MINU:  simple_res = ult ? in_a : in_b;
            bma_pkg::OP_SEXTB: simple_res = {{56{in_a[7]}}, in_a[7:0]};
            bma_pkg::OP_SEXTH: simple_res = {{48{in_a[15]}}, in_a[15:0]};
            bma_pkg::OP_ZEXTH: simple_res = {48'd0, in_a[15:0]};
            bma_pkg::OP_ORCB:  simple_res = orcb;
            bma_pkg::OP_REV8:  simple_res = rev8;
            default:           simple_res = '0;
        endcase
    end

    // Right-rotate amount; a left rotate becomes a right rotate by the negation
    always_comb
    begin
        case (in_op)
            bma_pkg::OP_ROL:   amt = 6'(7'd64 - {1'b0, in_b[5:0]});
            bma_pkg::OP_ROLW:  amt = {1'b0, 5'(6'd32 - {1'b0, in_b[4:0]})};
            bma_pkg::OP_RORIW,
            bma_pkg::OP_RORW:  amt = {1'b0, in_b[4:0]};
            default:           amt = in_b[5:0];
        endcase
        // Word rotates use a duplicated low word so a 64-bit rotate matches
        case (in_op)
            bma_pkg::OP_ROLW,
            bma_pkg::OP_RORIW,
            bma_pkg::OP_RORW:  rot_src = {in_a[31:0], in_a[31:0]};
            default:           rot_src = in_a;
        endcase
        rot_dbl = {rot_src, rot_src} >> {amt[5:3], 3'b000};
    end

    // Trailing-zero source; leading counts use the reversed operand,
    // word counts place a stop bit above the low word
    always_comb
    begin
        case (in_op)
            bma_pkg::OP_CLZ:   cnt_src = rev_a;
            bma_pkg::OP_CLZW:  cnt_src = {31'd0, 1'b1, rev_a[63:32]};
            bma_pkg::OP_CTZW:  cnt_src = {31'd0, 1'b1, in_a[31:0]};
            default:           cnt_src = in_a;
        endcase
        pop_src = (in_op == bma_pkg::OP_CPOPW) ? {32'd0, in_a[31:0]} : in_a;
        for (int k = 0; k < bma_pkg::NBYTES; k++)
        begin
            data_next.pcnt[k] = byte_pop(pop_src[k*8 +: 8]);
            data_next.nz[k]   = |cnt_src[k*8 +: 8];
            data_next.tz[k]   = byte_tz(cnt_src[k*8 +: 8]);
        end
        data_next.op       = in_op;
        data_next.simple   = simple_res;
        data_next.rot      = rot_dbl[bma_pkg::XLEN-1:0];
        data_next.fine_amt = amt[2:0];
    end

    // Stage register with valid bit
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/bma_reduce.sv]
// Stage 2 of the bit-manipulation pipeline: fine bit rotate, population
// sum and first-set-bit search over the per-byte terms.
// Depends on bma_pkg.
module bma_reduce (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  bma_pkg::s1_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output bma_pkg::s2_t out_data
);

    logic                        valid_reg;
    bma_pkg::s2_t                data_reg;
    bma_pkg::s2_t                data_next;
    logic [2*bma_pkg::XLEN-1:0]  rot_dbl;
    logic [bma_pkg::CNT_W-1:0]   pop_sum;
    logic [bma_pkg::CNT_W-1:0]   zero_cnt;

    // Finish the rotate and reduce the byte terms
    always_comb
    begin
        rot_dbl = {in_data.rot, in_data.rot} >> in_data.fine_amt;
        pop_sum = '0;
        for (int k = 0; k < bma_pkg::NBYTES; k++)
        begin
            pop_sum = pop_sum + bma_pkg::CNT_W'(in_data.pcnt[k]);
        end
        // No set bit anywhere counts the full width
        zero_cnt = bma_pkg::CNT_W'(bma_pkg::XLEN);
        for (int k = bma_pkg::NBYTES - 1; k >= 0; k--)
        begin
            if (in_data.nz[k])
            begin
                zero_cnt = {1'b0, 3'(k), in_data.tz[k]};
            end
        end
        data_next.op     = in_data.op;
        data_next.simple = in_data.simple;
        data_next.rot    = rot_dbl[bma_pkg::XLEN-1:0];
        case (in_data.op)
            bma_pkg::OP_CPOP,
            bma_pkg::OP_CPOPW: data_next.cnt = pop_sum;
            default:           data_next.cnt = zero_cnt;
        endcase
    end

    // Stage register with valid bit
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/bma_final.sv]
// Stage 3 of the bit-manipulation pipeline: result select, word sign
// extension and the output register.
// Depends on bma_pkg.
module bma_final (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  bma_pkg::s2_t             in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [bma_pkg::XLEN-1:0] out_result
);

    logic                     valid_reg;
    logic [bma_pkg::XLEN-1:0] result_reg;
    logic [bma_pkg::XLEN-1:0] result_next;

    // Pick the result by operation
    always_comb
    begin
        case (in_data.op)
            bma_pkg::OP_CLZ,
            bma_pkg::OP_CLZW,
            bma_pkg::OP_CTZ,
            bma_pkg::OP_CTZW,
            bma_pkg::OP_CPOP,
            bma_pkg::OP_CPOPW:
                result_next = bma_pkg::XLEN'(in_data.cnt);
            bma_pkg::OP_ROL,
            bma_pkg::OP_ROR,
            bma_pkg::OP_RORI:
                result_next = in_data.rot;
            bma_pkg::OP_ROLW,
            bma_pkg::OP_RORIW,
            bma_pkg::OP_RORW:
                result_next = {{32{in_data.rot[31]}}, in_data.rot[31:0]};
            default:
                result_next = in_data.simple;
        endcase
    end

    // Output register with valid bit
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

[design/bitmanip_alu_unit.sv]
// 64-bit bit-manipulation unit, three-stage pipeline.
//
// Input stream: s_axis_tuser carries the operation code, s_axis_tdata the
// two 64-bit source operands (operand_a low, operand_b high; for the
// immediate rotates the shift amount sits in operand_b). A transfer takes
// place on a rising edge with tvalid and tready both high.
// Output stream: m_axis_tdata carries the 64-bit result, one result for
// each input transfer, in order.
//
// Each item is registered by stage 1, stage 2 and then the output stage,
// where it raises m_axis_tvalid. Throughput is one operation per cycle while
// m_axis_tready is high: each stage holds one item with its own valid bit,
// so a new item enters while earlier ones are still in flight.
// Reset clears all valid bits; the unit is ready in the first cycle after.
// When the receiver holds m_axis_tready low, the output register keeps its
// result and each stage stalls only if the one after it is full, so items
// are neither dropped nor repeated. s_axis_tready falls once all three
// stages are occupied and stalled.
// Depends on bma_pkg, bma_prep, bma_reduce, bma_final.
module bitmanip_alu_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // [63:0] operand_a, [127:64] operand_b
    input  logic [4:0]    s_axis_tuser,   // [4:0] mode
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata    // [63:0] result
);

    logic          s1_valid;
    logic          s1_ready;
    bma_pkg::s1_t  s1_data;
    logic          s2_valid;
    logic          s2_ready;
    bma_pkg::s2_t  s2_data;

    // Stage 1: decode and per-byte terms
    bma_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (bma_pkg::op_t'(s_axis_tuser)),
        .in_a      (s_axis_tdata[63:0]),
        .in_b      (s_axis_tdata[127:64]),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Stage 2: reductions and fine rotate
    bma_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stage 3: result select and output register
    bma_final u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_ready   (s2_ready),
        .in_data    (s2_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (m_axis_tdata)
    );

endmodule

[design/bma_checker.sv]
// Port-level checks for the bit-manipulation unit, attached by bind.
// Depends on bma_pkg and bitmanip_alu_unit.
module bma_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [127:0] s_axis_tdata,
    input logic [4:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata
);

    logic s_xfer;
    logic andn_xfer;

    assign s_xfer    = s_axis_tvalid && s_axis_tready;
    assign andn_xfer = s_xfer && (s_axis_tuser == bma_pkg::OP_ANDN);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // A free receiver never blocks the input
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is ready");

    // A result after an empty pipeline has a matching earlier input transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_xfer, 3))
        else $error("result appeared without a matching input transfer");

    // With no stall, an andn result reaches the output and is correct
    a_andn: assert property (@(posedge clk) disable iff (!rst_n)
        $past(andn_xfer, 3) && $past(m_axis_tready, 1) && $past(m_axis_tready, 2)
        |-> m_axis_tvalid &&
            (m_axis_tdata == ($past(s_axis_tdata[63:0], 3) & ~$past(s_axis_tdata[127:64], 3))))
        else $error("andn result wrong or late");

    // Valid is clear in the first cycle out of reset
    a_reset: assert property (@(posedge clk)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind bitmanip_alu_unit bma_checker u_bma_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[dv/bitmanip_alu_unit_tb.sv]
// Self-checking testbench for bitmanip_alu_unit: directed and random operations
// over the stream ports, with a built-in predictor and an in-order result check.
// Depends on bma_pkg and the bitmanip_alu_unit RTL.
`timescale 1ns / 1ps

module bitmanip_alu_unit_tb;

    // Codes past the last defined operation; the unit returns zero for them
    localparam logic [4:0]  MODE_UNUSED_LO   = 5'd24;
    localparam logic [4:0]  MODE_UNUSED_HI   = 5'd31;
    localparam int          STALL_LIMIT      = 1000;
    localparam int          DRAIN_CYCLES     = 10;
    localparam int          RX_HOLD_CYCLES   = 150;
    localparam logic [15:0] RX_STALL_PATTERN = 16'b1110_0110_1011_0111;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata = '0;   // [63:0] operand_a, [127:64] operand_b
    logic [4:0]    s_axis_tuser = '0;   // [4:0] mode
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [63:0]   m_axis_tdata;        // [63:0] result

    logic [63:0]   results_due[$];
    int            mismatch_count = 0;
    bit            bursty = 1'b0;
    int            burst_left = 0;
    rx_style_t     rx_style = RX_RANDOM;
    int            rx_hold_left = 0;
    logic [3:0]    rx_phase = '0;

    bitmanip_alu_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] rot_right64(logic [63:0] x, logic [5:0] s);
        if (s == 6'd0)
            return x;
        return (x >> s) | (x << (64 - int'(s)));
    endfunction

    // Rotate the low word right and sign-extend the 32-bit result
    function automatic logic [63:0] rot_right_word(logic [31:0] x, logic [4:0] s);
        logic [31:0] w;
        w = (s == 5'd0) ? x : ((x >> s) | (x << (32 - int'(s))));
        return {{32{w[31]}}, w};
    endfunction

    // Count zeros from the top or the bottom of the low 'width' bits
    function automatic logic [63:0] zero_run(logic [63:0] x, int width, bit from_top);
        logic [63:0] n;
        n = '0;
        for (int i = 0; i < width; i++)
        begin
            if (x[from_top ? width - 1 - i : i])
                break;
            n++;
        end
        return n;
    endfunction

    function automatic logic [63:0] bitmanip_result(logic [4:0] mode, logic [63:0] a,
                                                    logic [63:0] b);
        logic [63:0] r;
        r = '0;
        case (mode)
            bma_pkg::OP_ANDN:  r = a & ~b;
            bma_pkg::OP_ORN:   r = a | ~b;
            bma_pkg::OP_XNOR:  r = ~(a ^ b);
            bma_pkg::OP_CLZ:   r = zero_run(a, 64, 1'b1);
            bma_pkg::OP_CLZW:  r = zero_run({32'd0, a[31:0]}, 32, 1'b1);
            bma_pkg::OP_CTZ:   r = zero_run(a, 64, 1'b0);
            bma_pkg::OP_CTZW:  r = zero_run({32'd0, a[31:0]}, 32, 1'b0);
            bma_pkg::OP_CPOP:  r = 64'($countones(a));
            bma_pkg::OP_CPOPW: r = 64'($countones(a[31:0]));
            bma_pkg::OP_MAX:   r = ($signed(a) < $signed(b)) ? b : a;
            bma_pkg::OP_MAXU:  r = (a < b) ? b : a;
            bma_pkg::OP_MIN:   r = ($signed(a) < $signed(b)) ? a : b;
            bma_pkg::OP_MINU:  r = (a < b) ? a : b;
            bma_pkg::OP_SEXTB: r = {{56{a[7]}}, a[7:0]};
            bma_pkg::OP_SEXTH: r = {{48{a[15]}}, a[15:0]};
            bma_pkg::OP_ZEXTH: r = {48'd0, a[15:0]};
            // left rotate is a right rotate by the negated amount
            bma_pkg::OP_ROL:   r = rot_right64(a, 6'd0 - b[5:0]);
            bma_pkg::OP_ROLW:  r = rot_right_word(a[31:0], 5'd0 - b[4:0]);
            bma_pkg::OP_ROR,
            bma_pkg::OP_RORI:  r = rot_right64(a, b[5:0]);
            bma_pkg::OP_RORIW,
            bma_pkg::OP_RORW:  r = rot_right_word(a[31:0], b[4:0]);
            bma_pkg::OP_ORCB:
            begin
                for (int i = 0; i < 8; i++)
                    r[8*i +: 8] = (a[8*i +: 8] != 8'd0) ? 8'hFF : 8'h00;
            end
            bma_pkg::OP_REV8:
            begin
                for (int i = 0; i < 8; i++)
                    r[8*i +: 8] = a[8*(7-i) +: 8];
            end
            default:  r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one operation, hold it until the transfer, then queue its result
    task automatic send_op(input logic [4:0] mode, input logic [63:0] a, input logic [63:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        results_due.push_back(bitmanip_result(mode, a, b));
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
    endtask

    // Draw an operand from classes that reach the corner cases
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'd1 << $urandom_range(0, 63);
            3:       v = ~(64'd1 << $urandom_range(0, 63));
            4:       v = 64'($urandom_range(0, 63));
            5:       v = {$urandom(), 32'd0};
            6:       v = {32'd0, $urandom()};
            7:       v = {$urandom(), $urandom()} & {$urandom(), $urandom()}
                         & {$urandom(), $urandom()};
            8:       v = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                              : 64'h7FFF_FFFF_FFFF_FFFF;
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    task automatic send_random_op();
        logic [4:0]  mode;
        logic [63:0] a;
        logic [63:0] b;
        if ($urandom_range(0, 15) == 0)
            mode = 5'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        else
            mode = 5'($urandom_range(bma_pkg::OP_ANDN, bma_pkg::OP_REV8));
        a = pick_operand();
        b = ($urandom_range(0, 15) == 0) ? a : pick_operand();
        send_op(mode, a, b);
    endtask

    // Drop tvalid and hold until every queued result has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Hold off when asked, else follow the current stall style
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left--;
        end
        else
        begin
            case (rx_style)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    m_axis_tready <= RX_STALL_PATTERN[rx_phase];
                    rx_phase <= rx_phase + 4'd1;
                end
            endcase
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        logic [63:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $display("%0t: result mismatch: expected %h, actual %h",
                             $time, want, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when nothing transfers for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("** bitmanip_alu_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        bursty   = 1'b1;
        rx_style = RX_RANDOM;
        // logic ops at the operand extremes
        send_op(bma_pkg::OP_ANDN,  '1, '0);
        send_op(bma_pkg::OP_ORN,   '0, '0);
        send_op(bma_pkg::OP_XNOR,  64'hA5A5_5A5A_0FF0_F00F, '1);
        // counts, including a zero operand and a zero low word
        send_op(bma_pkg::OP_CLZ,   '0, '0);
        send_op(bma_pkg::OP_CLZ,   64'h8000_0000_0000_0000, '0);
        send_op(bma_pkg::OP_CLZW,  64'hFFFF_FFFF_0000_0000, '0);
        send_op(bma_pkg::OP_CTZ,   '0, '1);
        send_op(bma_pkg::OP_CTZW,  64'h0000_0001_0000_0000, '0);
        send_op(bma_pkg::OP_CPOP,  '1, '0);
        send_op(bma_pkg::OP_CPOPW, '1, '0);
        // min/max across the sign boundary
        send_op(bma_pkg::OP_MAX,   64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_op(bma_pkg::OP_MAXU,  64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_op(bma_pkg::OP_MIN,   64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_op(bma_pkg::OP_MINU,  '1, '0);
        // extensions
        send_op(bma_pkg::OP_SEXTB, 64'h0000_0000_0000_0080, '0);
        send_op(bma_pkg::OP_SEXTH, 64'h1234_5678_9ABC_8000, '0);
        send_op(bma_pkg::OP_ZEXTH, '1, '0);
        // rotates: zero amount, ignored upper amount bits, sign-extended words
        send_op(bma_pkg::OP_ROL,   64'h8000_0000_0000_0001, '0);
        send_op(bma_pkg::OP_ROLW,  64'hDEAD_BEEF_4000_0000, 64'hFFFF_FFFF_FFFF_FFE1);
        send_op(bma_pkg::OP_ROR,   64'h0000_0000_0000_0001, 64'h0000_0000_0000_FFC1);
        send_op(bma_pkg::OP_RORI,  64'h0123_4567_89AB_CDEF, 64'd63);
        send_op(bma_pkg::OP_RORIW, 64'hFFFF_FFFF_0000_0001, 64'd1);
        send_op(bma_pkg::OP_RORW,  64'h0000_0000_8000_0000, 64'h0000_0000_0000_0020);
        // byte ops
        send_op(bma_pkg::OP_ORCB,  64'h0100_0000_0080_0000, '0);
        send_op(bma_pkg::OP_REV8,  64'h0102_0304_0506_0708, '0);
        // codes with no operation
        send_op(MODE_UNUSED_LO, '1, '1);
        send_op(MODE_UNUSED_HI, '1, '1);
        wait_drained();
    endtask

    // Back-to-back transfers with the receiver always ready
    task automatic test_full_rate();
        bursty   = 1'b0;
        rx_style = RX_ALWAYS;
        repeat (300) send_random_op();
        wait_drained();
    endtask

    // Hold the output off while input keeps coming so the pipe fills and stalls
    task automatic test_output_backpressure();
        bursty       = 1'b0;
        rx_style     = RX_ALWAYS;
        rx_hold_left = RX_HOLD_CYCLES;
        repeat (40) send_random_op();
        wait_drained();
    endtask

    task automatic test_random_operations();
        bursty   = 1'b1;
        rx_style = RX_RANDOM;
        repeat (500) send_random_op();
        wait_drained();
    endtask

    task automatic test_random_flow();
        bursty   = 1'b1;
        rx_style = RX_PATTERN;
        repeat (400) send_random_op();
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_rate();
        test_output_backpressure();
        test_random_operations();
        test_random_flow();

        // let any stray result show up before the verdict
        rx_style = RX_ALWAYS;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_due.size() == 0)
            $display("** bitmanip_alu_unit: PASSED **");
        else
            $display("** bitmanip_alu_unit: FAILED **");
        $finish;
    end

endmodule
